[src/midpoint_ellipse_rasterizer_core_macros.svh]
// assertion macros for the midpoint ellipse rasterizer
// both sample on i_clk and are off while i_rst_n is low
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication
`define MERC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MERC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/merc_pkg.sv]
package merc_pkg;

    // fixed result field widths
    localparam int PIX_W   = 12;
    localparam int COLOR_W = 24;
    localparam int OUT_W   = 2 * PIX_W + COLOR_W;

    // input kind carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // quadrant index of the fourth point of a set
    localparam logic [1:0] LAST_QUAD = 2'd3;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_STEP1,
        OP_STEP2,
        OP_INIT_MUL,
        OP_INIT_SUM,
        OP_C1,
        OP_C2,
        OP_R1_UPD,
        OP_R2_UPD,
        OP_ASQ,
        OP_RYA2,
        OP_BSQ,
        OP_RXB2,
        OP_RXRY,
        OP_R2_INIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       emit;
        logic [1:0] quad;
        logic       done;
    } t_dp_cmd;

    typedef struct packed {
        logic in_ry_zero;
        logic c1_ge_c2;
        logic y_zero;
    } t_dp_sts;

endpackage

[src/merc_dp.sv]
module merc_dp #(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  merc_pkg::t_dp_cmd             i_cmd,
    output merc_pkg::t_dp_sts             o_sts,
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic                          i_cfg_valid,
    input  logic [merc_pkg::COLOR_W-1:0]  i_cfg_data,
    output logic [merc_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast,
    output logic [0:0]                    o_m_tuser
);

    localparam int XW  = RADIUS_BITS + 2;
    localparam int YW  = RADIUS_BITS;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int AW  = RADIUS_BITS + 3;
    localparam int BW  = 2 * AW;
    localparam int PW  = SQW + BW;
    localparam int TW  = PW + 1;
    localparam int DW  = TW + 2;
    localparam int SW0 = (COORD_BITS > XW) ? COORD_BITS : XW;
    localparam int SW  = ((SW0 > merc_pkg::PIX_W) ? SW0 : merc_pkg::PIX_W) + 1;

    logic [COORD_BITS-1:0]  in_cx;
    logic [COORD_BITS-1:0]  in_cy;
    logic [RADIUS_BITS-1:0] in_rx;
    logic [RADIUS_BITS-1:0] in_ry;

    logic [COORD_BITS-1:0]      r_cx;
    logic [COORD_BITS-1:0]      r_cy;
    logic [XW-1:0]              r_x;
    logic [YW-1:0]              r_y;
    logic [SQW-1:0]             r_rx2;
    logic [SQW-1:0]             r_ry2;
    logic [TW-1:0]              r_t1;
    logic [TW-1:0]              r_t2;
    logic [TW-1:0]              r_t3;
    logic signed [DW-1:0]       r_dec;
    logic                       r_dir;
    logic [merc_pkg::COLOR_W-1:0] r_color;
    logic [merc_pkg::PIX_W-1:0] r_px;
    logic [merc_pkg::PIX_W-1:0] r_py;
    logic [merc_pkg::COLOR_W-1:0] r_ocol;
    logic                       r_last;
    logic                       r_done;

    logic [AW-1:0]        a_val;
    logic [YW-1:0]        b_mag;
    logic [SQW-1:0]       mul_a;
    logic [BW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    logic                 dec_neg;
    logic                 dec_zero;
    logic signed [DW-1:0] v_init;
    logic signed [DW-1:0] v_r2;
    logic signed [DW-1:0] r1_upd;
    logic signed [DW-1:0] r2_upd;
    logic [SW-1:0]        sum_x;
    logic [SW-1:0]        sum_y;

    function automatic logic signed [DW-1:0] ext_t(input logic [TW-1:0] v);
        return signed'({2'b00, v});
    endfunction

    function automatic logic signed [DW-1:0] ext_sq(input logic [SQW-1:0] v);
        return signed'(DW'(v));
    endfunction

    // divide by four, rounding toward zero
    function automatic logic signed [DW-1:0] quarter(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] biased;
        biased = v[DW-1] ? v + DW'(3) : v;
        return biased >>> 2;
    endfunction

    assign in_cx = i_s_tdata[COORD_BITS-1:0];
    assign in_cy = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_rx = i_s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
    assign in_ry = i_s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

    assign a_val    = {r_x, 1'b1};
    assign b_mag    = (r_y == '0) ? YW'(1) : r_y - YW'(1);
    assign dec_neg  = r_dec[DW-1];
    assign dec_zero = (r_dec == '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            merc_pkg::OP_INIT_MUL: begin
                mul_a = r_rx2;
                mul_b = BW'(r_y);
            end
            merc_pkg::OP_C1: begin
                mul_a = r_ry2;
                mul_b = BW'(r_x);
            end
            merc_pkg::OP_C2: begin
                mul_a = r_rx2;
                mul_b = BW'(r_y);
            end
            merc_pkg::OP_ASQ: begin
                mul_a = SQW'(a_val);
                mul_b = BW'(a_val);
            end
            merc_pkg::OP_RYA2: begin
                mul_a = r_ry2;
                mul_b = r_t1[BW-1:0];
            end
            merc_pkg::OP_BSQ: begin
                mul_a = SQW'(b_mag);
                mul_b = BW'(b_mag);
            end
            merc_pkg::OP_RXB2: begin
                mul_a = r_rx2;
                mul_b = r_t2[BW-1:0];
            end
            merc_pkg::OP_RXRY: begin
                mul_a = r_rx2;
                mul_b = BW'(r_ry2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign v_init = (ext_sq(r_ry2) <<< 2) - (ext_t(r_t3) <<< 2) + ext_sq(r_rx2);
    assign v_r2   = ext_t(r_t1) + (ext_t(r_t2) <<< 2) - (ext_t(r_t3) <<< 2);
    assign r1_upd = r_dec + ext_t(r_t1) - (r_dir ? ext_t(r_t2) : '0) + ext_sq(r_ry2);
    assign r2_upd = r_dec + (r_dir ? ext_t(r_t1) : '0) - ext_t(r_t2) + ext_sq(r_rx2);

    // quadrant point: bit 0 mirrors x, bit 1 mirrors y
    assign sum_x = i_cmd.quad[0] ? SW'(r_cx) - SW'(r_x) : SW'(r_cx) + SW'(r_x);
    assign sum_y = i_cmd.quad[1] ? SW'(r_cy) - SW'(r_y) : SW'(r_cy) + SW'(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            merc_pkg::OP_START: begin
                r_cx  <= in_cx;
                r_cy  <= in_cy;
                r_rx2 <= in_rx * in_rx;
                r_ry2 <= in_ry * in_ry;
                r_x   <= '0;
                r_y   <= in_ry;
            end
            merc_pkg::OP_STEP1: begin
                r_x   <= r_x + XW'(1);
                r_dir <= !dec_neg;
                if (!dec_neg) begin
                    r_y <= r_y - YW'(1);
                end
            end
            merc_pkg::OP_STEP2: begin
                r_y   <= r_y - YW'(1);
                r_dir <= dec_neg || dec_zero;
                if (dec_neg || dec_zero) begin
                    r_x <= r_x + XW'(1);
                end
            end
            merc_pkg::OP_INIT_MUL: r_t3  <= {1'b0, mul_p};
            merc_pkg::OP_INIT_SUM: r_dec <= quarter(v_init);
            merc_pkg::OP_C1:       r_t1  <= {mul_p, 1'b0};
            merc_pkg::OP_C2:       r_t2  <= {mul_p, 1'b0};
            merc_pkg::OP_R1_UPD:   r_dec <= r1_upd;
            merc_pkg::OP_R2_UPD:   r_dec <= r2_upd;
            merc_pkg::OP_ASQ:      r_t1  <= {1'b0, mul_p};
            merc_pkg::OP_RYA2:     r_t1  <= {1'b0, mul_p};
            merc_pkg::OP_BSQ:      r_t2  <= {1'b0, mul_p};
            merc_pkg::OP_RXB2:     r_t2  <= {1'b0, mul_p};
            merc_pkg::OP_RXRY:     r_t3  <= {1'b0, mul_p};
            merc_pkg::OP_R2_INIT:  r_dec <= quarter(v_r2);
            default: begin
            end
        endcase
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px   <= sum_x[merc_pkg::PIX_W-1:0];
            r_py   <= sum_y[merc_pkg::PIX_W-1:0];
            r_ocol <= r_color;
            r_last <= (i_cmd.quad == merc_pkg::LAST_QUAD);
            r_done <= i_cmd.done;
        end
    end

    assign o_sts.in_ry_zero = (in_ry == '0);
    assign o_sts.c1_ge_c2   = (r_t1 >= r_t2);
    assign o_sts.y_zero     = (r_y == '0);

    assign o_m_tdata = {r_ocol, r_py, r_px};
    assign o_m_tlast = r_last;
    assign o_m_tuser = r_done;

endmodule

[src/merc_ctrl.sv]
module merc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [0:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output merc_pkg::t_dp_cmd o_cmd,
    input  merc_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_MUL,
        S_INIT_SUM,
        S_C1,
        S_C2,
        S_CMP,
        S_ASQ,
        S_RYA2,
        S_BSQ,
        S_RXB2,
        S_RXRY,
        S_R2_INIT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_DONE
    } t_phase;

    t_state     r_state;
    t_phase     r_phase;
    logic       r_done;
    logic [1:0] r_quad;
    logic       r_out_valid;

    logic accept;
    logic out_free;

    assign o_s_tready = i_rst_n && (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd.op   = merc_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        o_cmd.quad = r_quad;
        o_cmd.done = r_done;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[0] == merc_pkg::MODE_START) begin
                        o_cmd.op = merc_pkg::OP_START;
                    end else if (r_phase == PH_ONE) begin
                        o_cmd.op = merc_pkg::OP_STEP1;
                    end else if (r_phase == PH_TWO) begin
                        o_cmd.op = merc_pkg::OP_STEP2;
                    end
                end
            end
            S_INIT_MUL: o_cmd.op = merc_pkg::OP_INIT_MUL;
            S_INIT_SUM: o_cmd.op = merc_pkg::OP_INIT_SUM;
            S_C1:       o_cmd.op = merc_pkg::OP_C1;
            S_C2:       o_cmd.op = merc_pkg::OP_C2;
            S_CMP: begin
                if (r_phase == PH_TWO) begin
                    o_cmd.op = merc_pkg::OP_R2_UPD;
                end else if (!i_sts.c1_ge_c2) begin
                    o_cmd.op = merc_pkg::OP_R1_UPD;
                end
            end
            S_ASQ:     o_cmd.op = merc_pkg::OP_ASQ;
            S_RYA2:    o_cmd.op = merc_pkg::OP_RYA2;
            S_BSQ:     o_cmd.op = merc_pkg::OP_BSQ;
            S_RXB2:    o_cmd.op = merc_pkg::OP_RXB2;
            S_RXRY:    o_cmd.op = merc_pkg::OP_RXRY;
            S_R2_INIT: o_cmd.op = merc_pkg::OP_R2_INIT;
            S_EMIT:    o_cmd.emit = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_done      <= 1'b0;
            r_quad      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_s_tuser[0] == merc_pkg::MODE_START) begin
                            r_phase <= i_sts.in_ry_zero ? PH_DONE : PH_ONE;
                            r_done  <= i_sts.in_ry_zero;
                            r_state <= S_INIT_MUL;
                        end else if (r_phase inside {PH_ONE, PH_TWO}) begin
                            r_done  <= 1'b0;
                            r_state <= S_C1;
                        end
                    end
                end
                S_INIT_MUL: r_state <= S_INIT_SUM;
                S_INIT_SUM: r_state <= S_EMIT;
                S_C1:       r_state <= S_C2;
                S_C2:       r_state <= S_CMP;
                S_CMP: begin
                    if (r_phase == PH_TWO) begin
                        if (i_sts.y_zero) begin
                            r_phase <= PH_DONE;
                            r_done  <= 1'b1;
                        end
                        r_state <= S_EMIT;
                    end else if (i_sts.c1_ge_c2) begin
                        r_state <= S_ASQ;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_ASQ:  r_state <= S_RYA2;
                S_RYA2: r_state <= S_BSQ;
                S_BSQ:  r_state <= S_RXB2;
                S_RXB2: r_state <= S_RXRY;
                S_RXRY: r_state <= S_R2_INIT;
                S_R2_INIT: begin
                    r_phase <= i_sts.y_zero ? PH_DONE : PH_TWO;
                    r_done  <= i_sts.y_zero;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_quad <= r_quad + 2'd1;
                        if (r_quad == merc_pkg::LAST_QUAD) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/midpoint_ellipse_rasterizer_core.sv]
// Midpoint ellipse outline rasterizer. A start item (tuser 0) takes the centre and both radii
// from tdata and plots (0, ry) in all four quadrants; each step item (tuser 1) advances one
// point along the curve in region one, then region two, and plots it four times, in the order
// (cx+x, cy+y), (cx-x, cy+y), (cx+x, cy-y), (cx-x, cy-y). tlast marks the fourth point of a
// set and tuser marks every point of the set that completes the ellipse. Step items that come
// before any start or after the ellipse is complete are taken and give nothing. A start item
// always abandons any ellipse in progress. A start runs the transfer, the product and sum that
// set up the decision value, and four points; an ordinary step the transfer, two products on
// the one shared multiplier, the decision update and four points; the step that crosses into
// region two also five more products and one sum to set up the new decision value. The single
// output channel moves one point per cycle while ready, and the input is taken again while
// the fourth point still waits in the output register. Both input channels stay not ready
// while reset is held. The user must write the outline color register, over its own channel
// (always ready out of reset), only while the block is idle; the block does not enforce it.
module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // outline color register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [merc_pkg::COLOR_W-1:0]  i_cfg_data,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // centre_x, centre_y, radius_x, radius_y, zero padding
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] i_s_tdata,
    // mode (0 start, 1 step)
    input  logic [0:0]                    i_s_tuser,
    // pixel stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [merc_pkg::OUT_W-1:0]    o_m_tdata,
    // last_of_run
    output logic                          o_m_tlast,
    // ellipse_done
    output logic [0:0]                    o_m_tuser
);

    merc_pkg::t_dp_cmd cmd;
    merc_pkg::t_dp_sts sts;

    // color register takes every write at once, out of reset
    assign o_cfg_ready = i_rst_n;

    // sequencer: phase, operation order and output handshake
    merc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // point, decision value, shared multiplier and output payload
    merc_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

[src/merc_checker.sv]
`include "midpoint_ellipse_rasterizer_core_macros.svh"

module merc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [merc_pkg::OUT_W-1:0] o_m_tdata,
    input logic                       o_m_tlast,
    input logic [0:0]                 o_m_tuser
);

    // stalled pixel stays put
    `MERC_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled pixel changed")

    // points of one set follow back to back
    `MERC_ASSERT_NXT(a_set_no_gap, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "gap inside a point set")

    // completion flag is the same on every point of a set
    `MERC_ASSERT_NXT(a_done_steady, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tuser == $past(o_m_tuser), "done flag changed inside a set")

    // no new item is taken while a set is still going out
    `MERC_ASSERT_IMP(a_no_accept_mid_set, o_m_tvalid && !o_m_tlast, !o_s_tready, "input ready during a point set")

endmodule

bind midpoint_ellipse_rasterizer_core merc_checker u_merc_checker (.*);

[verif/midpoint_ellipse_rasterizer_core_tb.sv]
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_core_tb;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transfer at all before giving up
    localparam int SINK_HOLD   = 80;     // length of the long output back-pressure stretch
    localparam int SETTLE      = 20;     // covers the slowest item plus margin
    localparam int PIX_BITS    = merc_pkg::PIX_W;
    localparam int COLOR_BITS  = merc_pkg::COLOR_W;
    localparam int OUT_BITS    = merc_pkg::OUT_W;

    // outline tracing phase of the ellipse being drawn
    typedef enum logic [1:0] {
        TRACE_IDLE,
        TRACE_REGION1,
        TRACE_REGION2,
        TRACE_FINISHED
    } t_trace_phase;

    // one input item waiting to be offered
    typedef struct {
        bit       mode;
        bit [9:0] cx;
        bit [9:0] cy;
        bit [7:0] rx;
        bit [7:0] ry;
    } t_stroke;

    // one expected outline pixel
    typedef struct {
        logic [PIX_BITS-1:0]   px;
        logic [PIX_BITS-1:0]   py;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  done;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [COLOR_BITS-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    // centre_x, centre_y, radius_x, radius_y, zero padding
    logic [39:0]           i_s_tdata   = '0;
    // mode
    logic [0:0]            i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // pixel_x, pixel_y, pixel_color
    logic [OUT_BITS-1:0]   o_m_tdata;
    // last_of_run
    logic                  o_m_tlast;
    // ellipse_done
    logic [0:0]            o_m_tuser;

    // pending input items and expected pixels
    t_stroke stroke_q[$];
    t_pixel  pixel_q[$];

    // predictor copy of the block state
    t_trace_phase          trace_phase = TRACE_IDLE;
    longint                pos_x, pos_y, decision, rx_sq, ry_sq;
    longint                held_cx, held_cy;
    logic [COLOR_BITS-1:0] outline_color = '0;

    // handshake flags between the monitor and the drivers
    bit item_taken;
    bit cfg_taken;
    bit sink_hold_req;
    bit idling_on = 1'b1;
    int source_gap, sink_gap, sink_hold;
    int quiet_cycles;

    // run statistics
    int mismatches, pixels_checked, starts_seen, steps_seen, steps_ignored;
    int ellipses_closed, colors_written;

    midpoint_ellipse_rasterizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // push the current point mirrored into all four quadrants
    task automatic push_quadrants(input bit done);
        t_pixel p;
        int     k;
        for (k = 0; k < 4; k++) begin
            p.px    = (k % 2 == 0) ? PIX_BITS'(held_cx + pos_x) : PIX_BITS'(held_cx - pos_x);
            p.py    = (k < 2) ? PIX_BITS'(held_cy + pos_y) : PIX_BITS'(held_cy - pos_y);
            p.color = outline_color;
            p.last  = (k == 3);
            p.done  = done;
            pixel_q.push_back(p);
        end
    endtask

    // advance the outline by one accepted item and queue its pixels
    task automatic trace_outline(input logic mode, input logic [9:0] cx,
                                 input logic [9:0] cy, input logic [7:0] rx,
                                 input logic [7:0] ry);
        longint c1, c2, a, b, rx_l, ry_l;
        bit     done, down, right;
        done = 1'b0;
        if (mode == merc_pkg::MODE_START) begin
            starts_seen++;
            rx_l    = longint'(rx);
            ry_l    = longint'(ry);
            held_cx = longint'(cx);
            held_cy = longint'(cy);
            rx_sq   = rx_l * rx_l;
            ry_sq   = ry_l * ry_l;
            pos_x   = 0;
            pos_y   = ry_l;
            // start-up terms are kept at four times their value, then truncated
            decision = (4 * ry_sq - 4 * rx_sq * ry_l + rx_sq) / 4;
            if (ry_l == 0) begin
                trace_phase = TRACE_FINISHED;
                done = 1'b1;
            end else begin
                trace_phase = TRACE_REGION1;
            end
            push_quadrants(done);
        end else if (trace_phase == TRACE_REGION1) begin
            steps_seen++;
            down = (decision >= 0);
            pos_x++;
            if (down)
                pos_y--;
            c1 = 2 * ry_sq * pos_x;
            c2 = 2 * rx_sq * pos_y;
            if (c1 >= c2) begin
                // slope crossed: region two decision from this point
                a = 2 * pos_x + 1;
                b = pos_y - 1;
                decision = (ry_sq * a * a + 4 * rx_sq * b * b - 4 * rx_sq * ry_sq) / 4;
                if (pos_y == 0) begin
                    trace_phase = TRACE_FINISHED;
                    done = 1'b1;
                end else begin
                    trace_phase = TRACE_REGION2;
                end
            end else if (down) begin
                decision = decision + c1 - c2 + ry_sq;
            end else begin
                decision = decision + c1 + ry_sq;
            end
            push_quadrants(done);
        end else if (trace_phase == TRACE_REGION2) begin
            steps_seen++;
            right = (decision <= 0);
            if (right)
                pos_x++;
            pos_y--;
            c1 = 2 * ry_sq * pos_x;
            c2 = 2 * rx_sq * pos_y;
            if (right)
                decision = decision + c1 - c2 + rx_sq;
            else
                decision = decision - c2 + rx_sq;
            if (pos_y <= 0) begin
                trace_phase = TRACE_FINISHED;
                done = 1'b1;
            end
            push_quadrants(done);
        end else begin
            // step with no ellipse in progress is dropped by the block
            steps_ignored++;
        end
        if (done)
            ellipses_closed++;
    endtask

    function automatic void check_field(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, what, want, got);
        end
    endfunction

    // monitor: predicts on input transfers, checks output transfers, watchdog
    always @(posedge i_clk) begin : bus_monitor
        t_pixel want;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                pixels_checked++;
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pixel, expected none, actual x 'h%0h y 'h%0h",
                             $time, o_m_tdata[11:0], o_m_tdata[23:12]);
                end else begin
                    want = pixel_q.pop_front();
                    check_field("pixel_x", 24'(want.px), 24'(o_m_tdata[11:0]));
                    check_field("pixel_y", 24'(want.py), 24'(o_m_tdata[23:12]));
                    check_field("pixel_color", want.color, o_m_tdata[47:24]);
                    check_field("last_of_run", 24'(want.last), 24'(o_m_tlast));
                    check_field("ellipse_done", 24'(want.done), 24'(o_m_tuser[0]));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                item_taken = 1'b1;
                trace_outline(i_s_tuser[0], i_s_tdata[9:0], i_s_tdata[19:10],
                              i_s_tdata[27:20], i_s_tdata[35:28]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                cfg_taken = 1'b1;
                outline_color = i_cfg_data;
                colors_written++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d pixels outstanding",
                         $time, QUIET_LIMIT, pixel_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // source driver: offers queued items, holds each until its transfer
    always @(negedge i_clk) begin : source_driver
        bit      offer;
        t_stroke head;
        offer = i_s_tvalid;
        if (item_taken) begin
            item_taken = 1'b0;
            void'(stroke_q.pop_front());
            offer = 1'b0;
        end
        if (!offer && i_rst_n) begin
            if (source_gap > 0) begin
                source_gap--;
            end else if (stroke_q.size() > 0) begin
                if (idling_on && $urandom_range(0, 5) == 0)
                    source_gap = int'($urandom_range(0, 3));
                else
                    offer = 1'b1;
            end
        end
        if (offer) begin
            head = stroke_q[0];
            i_s_tdata <= {4'b0, head.ry, head.rx, head.cy, head.cx};
            i_s_tuser <= head.mode;
        end
        i_s_tvalid <= offer;
    end

    // sink driver: random short back-pressure, plus one long hold on request
    always @(negedge i_clk) begin : sink_driver
        logic ready;
        ready = 1'b1;
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_hold = SINK_HOLD;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            ready = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            ready = 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            sink_gap = int'($urandom_range(0, 3));
            ready = 1'b0;
        end
        if (!i_rst_n)
            ready = 1'b0;
        i_m_tready <= ready;
    end

    task automatic queue_stroke(input bit mode, input bit [9:0] cx, input bit [9:0] cy,
                                input bit [7:0] rx, input bit [7:0] ry);
        t_stroke s;
        s.mode = mode;
        s.cx   = cx;
        s.cy   = cy;
        s.rx   = rx;
        s.ry   = ry;
        stroke_q.push_back(s);
    endtask

    // steps carry random payload, which the block must not look at
    task automatic queue_steps(input int count);
        repeat (count)
            queue_stroke(merc_pkg::MODE_STEP, 10'($urandom), 10'($urandom),
                         8'($urandom), 8'($urandom));
    endtask

    // sender pause: wait until every queued item went out and every pixel came back
    task automatic drain_results();
        while (stroke_q.size() != 0 || pixel_q.size() != 0)
            @(negedge i_clk);
    endtask

    // register write while idle; ignored steps may still be finishing
    task automatic write_outline_color(input logic [COLOR_BITS-1:0] value);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(negedge i_clk);
        while (!cfg_taken);
        cfg_taken = 1'b0;
        i_cfg_valid <= 1'b0;
    endtask

    // random ellipses: mostly small and complete, some abandoned, a few huge
    task automatic queue_random_strokes(input int budget);
        int       added, pick, steps;
        bit [7:0] rx, ry;
        added = 0;
        while (added < budget) begin
            pick = int'($urandom_range(0, 9));
            rx = 8'($urandom_range(1, 10));
            ry = 8'($urandom_range(1, 10));
            if (pick == 0) begin
                rx = 8'($urandom);
                ry = 8'($urandom);
            end else if (pick == 1) begin
                if ($urandom_range(0, 1))
                    rx = 8'd0;
                else
                    ry = 8'd0;
            end
            if (pick == 0 || pick == 2)
                steps = int'($urandom_range(0, 5));
            else
                steps = int'(rx) + int'(ry) + 1 + int'($urandom_range(0, 2));
            if (pick == 3) begin
                queue_steps(1);   // stray step between ellipses
                added++;
            end
            queue_stroke(merc_pkg::MODE_START, 10'($urandom), 10'($urandom), rx, ry);
            queue_steps(steps);
            added += steps + 1;
        end
    endtask

    initial begin : stimulus
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: step before any start, corners, both zero radii, abandon
        queue_steps(1);
        queue_stroke(merc_pkg::MODE_START, 10'd0, 10'd0, 8'd1, 8'd1);
        queue_steps(3);
        queue_stroke(merc_pkg::MODE_START, 10'd1023, 10'd1023, 8'd255, 8'd255);
        queue_steps(2);
        // zero vertical radius closes on the start set, the step after is dropped
        queue_stroke(merc_pkg::MODE_START, 10'd512, 10'd341, 8'd5, 8'd0);
        queue_steps(1);
        // zero horizontal radius: one region one step, then region two
        queue_stroke(merc_pkg::MODE_START, 10'd682, 10'd20, 8'd0, 8'd3);
        queue_steps(4);
        // flat ellipse: region one runs all the way down to y of zero
        queue_stroke(merc_pkg::MODE_START, 10'd100, 10'd900, 8'd8, 8'd1);
        queue_steps(8);
        drain_results();

        write_outline_color(24'hffffff);
        sink_hold_req = 1'b1;   // output stalls long enough to back up the input
        queue_random_strokes(30);
        drain_results();

        write_outline_color(24'h000000);
        queue_random_strokes(30);
        drain_results();

        // last part runs with no idling on either side
        write_outline_color(24'($urandom));
        idling_on = 1'b0;
        queue_random_strokes(30);
        drain_results();
        repeat (SETTLE) @(negedge i_clk);

        $display("run covered %0d starts, %0d traced steps, %0d dropped steps, %0d ellipses closed",
                 starts_seen, steps_seen, steps_ignored, ellipses_closed);
        $display("%0d pixels checked over %0d outline color writes, %0d mismatches",
                 pixels_checked, colors_written, mismatches);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
